[src/hrht_pkg.sv]
`timescale 1ns / 1ps

package hrht_pkg;

   // Default depth of the field capture buffer, in bytes
   localparam int MATCH_BYTES_DEFAULT = 8;

   // Longest name or version string in the tables
   localparam int TEXT_BYTES = 8;

   // Character codes that steer the parse
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Method names; text is right-justified, first character highest
   localparam int METHOD_COUNT = 8;
   localparam logic [63:0] METHOD_TEXT [METHOD_COUNT] = '{
      64'("OPTIONS"), 64'("GET"), 64'("HEAD"), 64'("POST"),
      64'("PUT"), 64'("DELETE"), 64'("TRACE"), 64'("CONNECT")
   };
   localparam int METHOD_LEN [METHOD_COUNT] = '{7, 3, 4, 4, 3, 6, 5, 7};

   // Protocol version strings
   localparam int VERSION_COUNT = 5;
   localparam logic [63:0] VERSION_TEXT [VERSION_COUNT] = '{
      64'("HTTP/0.9"), 64'("HTTP/1.0"), 64'("HTTP/1.1"), 64'("HTTP/2.0"),
      64'("HTTP/3.0")
   };
   localparam int VERSION_LEN [VERSION_COUNT] = '{8, 8, 8, 8, 8};

   localparam logic [3:0] METHOD_UNKNOWN  = 4'd0;
   localparam logic [2:0] VERSION_UNKNOWN = 3'd0;

   // Role tag carried with each byte
   typedef enum logic [2:0] {
      ROLE_METHOD = 3'd0,
      ROLE_URI    = 3'd1,
      ROLE_VER    = 3'd2,
      ROLE_SEP    = 3'd3,
      ROLE_NAME   = 3'd4,
      ROLE_VALUE  = 3'd5,
      ROLE_END    = 3'd6,
      ROLE_BODY   = 3'd7
   } role_type;

   // One result item
   typedef struct packed {
      logic [7:0] byte_out;
      role_type   role;
      logic [3:0] method_code;
      logic [2:0] version_code;
      logic       codes_valid;
      logic       header_end;
      logic       headers_done;
   } result_type;

endpackage

[src/hrht_match.sv]
`timescale 1ns / 1ps

module hrht_match
   import hrht_pkg::*;
#(
   parameter int MATCH_BYTES = MATCH_BYTES_DEFAULT,
   localparam int LEN_W = $clog2(MATCH_BYTES + 2)
) (
   input  logic [MATCH_BYTES-1:0][7:0] match_buf,
   input  logic [LEN_W-1:0]            match_len,
   input  logic [7:0]                  data_byte,
   input  logic                        push,
   output logic [3:0]                  method_code,
   output logic [2:0]                  version_code
);

   logic [TEXT_BYTES-1:0][7:0] view_byte;
   logic [LEN_W-1:0]           view_len;
   logic [METHOD_COUNT-1:0]    method_hit;
   logic [VERSION_COUNT-1:0]   version_hit;

   // Form the field as it stands with the current byte appended
   always_comb begin
      for (int k = 0; k < TEXT_BYTES; k++) begin
         view_byte[k] = (push && (match_len == LEN_W'(k))) ? data_byte : match_buf[k];
      end
      if (!push) begin
         view_len = match_len;
      end else if (match_len < LEN_W'(MATCH_BYTES)) begin
         view_len = match_len + LEN_W'(1);
      end else begin
         view_len = LEN_W'(MATCH_BYTES + 1);
      end
   end

   // Compare against every method name and version string; an overlong field fails on length
   always_comb begin
      for (int i = 0; i < METHOD_COUNT; i++) begin
         method_hit[i] = (view_len == LEN_W'(METHOD_LEN[i]));
         for (int k = 0; k < TEXT_BYTES; k++) begin
            if (k < METHOD_LEN[i]) begin
               if (view_byte[k] != METHOD_TEXT[i][8*(METHOD_LEN[i]-1-k) +: 8]) begin
                  method_hit[i] = 1'b0;
               end
            end
         end
      end
      for (int i = 0; i < VERSION_COUNT; i++) begin
         version_hit[i] = (view_len == LEN_W'(VERSION_LEN[i]));
         for (int k = 0; k < TEXT_BYTES; k++) begin
            if (k < VERSION_LEN[i]) begin
               if (view_byte[k] != VERSION_TEXT[i][8*(VERSION_LEN[i]-1-k) +: 8]) begin
                  version_hit[i] = 1'b0;
               end
            end
         end
      end
   end

   // Encode the first hit
   always_comb begin
      method_code = METHOD_UNKNOWN;
      for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
         if (method_hit[i]) begin
            method_code = 4'(i + 1);
         end
      end
      version_code = VERSION_UNKNOWN;
      for (int i = VERSION_COUNT - 1; i >= 0; i--) begin
         if (version_hit[i]) begin
            version_code = 3'(i + 1);
         end
      end
   end

endmodule

[src/hrht_parse.sv]
`timescale 1ns / 1ps

module hrht_parse
   import hrht_pkg::*;
#(
   parameter int MATCH_BYTES = MATCH_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last,
   output result_type result
);

   localparam int LEN_W = $clog2(MATCH_BYTES + 2);
   localparam int IDX_W = $clog2(MATCH_BYTES);

   typedef enum logic [7:0] {
      PH_METHOD      = 8'b0000_0001,
      PH_URI         = 8'b0000_0010,
      PH_VERSION     = 8'b0000_0100,
      PH_LINE_START  = 8'b0000_1000,
      PH_NAME        = 8'b0001_0000,
      PH_AFTER_COLON = 8'b0010_0000,
      PH_VALUE       = 8'b0100_0000,
      PH_BODY        = 8'b1000_0000
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [MATCH_BYTES-1:0][7:0] match_buf_ff;
   logic [LEN_W-1:0]            match_len_ff, match_len_in;
   logic [3:0]                  method_held_ff, method_held_in;
   logic                        skip_ff, skip_in;

   logic       push;
   logic       clear;
   logic       line_end;
   logic [3:0] match_method;
   logic [2:0] match_version;

   hrht_match #(
      .MATCH_BYTES (MATCH_BYTES)
   ) u_match (
      .match_buf    (match_buf_ff),
      .match_len    (match_len_ff),
      .data_byte    (data_byte),
      .push         (push),
      .method_code  (match_method),
      .version_code (match_version)
   );

   // Classify the byte and work out the next state
   always_comb begin
      phase_in       = phase_ff;
      method_held_in = method_held_ff;
      skip_in        = skip_ff;
      push           = 1'b0;
      clear          = 1'b0;
      line_end       = 1'b0;
      result         = '0;
      result.byte_out = data_byte;
      result.role     = ROLE_SEP;

      if (skip_ff) begin
         skip_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_METHOD, PH_URI, PH_VERSION: begin
               line_end = (data_byte == CHAR_CR);
               if (!line_end) begin
                  if (phase_ff == PH_METHOD) begin
                     if (data_byte == CHAR_SP) begin
                        method_held_in = match_method;
                        clear          = 1'b1;
                        phase_in       = PH_URI;
                     end else begin
                        push        = 1'b1;
                        result.role = ROLE_METHOD;
                     end
                  end else if (phase_ff == PH_URI) begin
                     if (data_byte == CHAR_SP) begin
                        clear    = 1'b1;
                        phase_in = PH_VERSION;
                     end else begin
                        result.role = ROLE_URI;
                     end
                  end else begin
                     push        = 1'b1;
                     result.role = ROLE_VER;
                  end
               end
               // Report the codes at the end of the line or of the buffer
               if (line_end || last) begin
                  result.codes_valid  = 1'b1;
                  result.method_code  = (phase_ff == PH_METHOD) ? match_method
                                                                : method_held_ff;
                  result.version_code = (phase_ff == PH_VERSION) ? match_version
                                                                 : VERSION_UNKNOWN;
               end
               if (line_end) begin
                  phase_in = PH_LINE_START;
                  skip_in  = 1'b1;
               end
            end
            PH_LINE_START: begin
               if (data_byte == CHAR_CR) begin
                  result.role         = ROLE_END;
                  result.headers_done = 1'b1;
                  phase_in            = PH_BODY;
                  skip_in             = 1'b1;
               end else if (data_byte == CHAR_COLON) begin
                  phase_in = PH_AFTER_COLON;
               end else begin
                  result.role = ROLE_NAME;
                  phase_in    = PH_NAME;
               end
            end
            PH_NAME: begin
               if (data_byte == CHAR_COLON) begin
                  phase_in = PH_AFTER_COLON;
               end else begin
                  result.role = ROLE_NAME;
               end
            end
            PH_AFTER_COLON, PH_VALUE: begin
               if ((phase_ff == PH_AFTER_COLON) && (data_byte == CHAR_SP)) begin
                  phase_in = PH_VALUE;
               end else if (data_byte == CHAR_CR) begin
                  result.header_end = 1'b1;
                  phase_in          = PH_LINE_START;
                  skip_in           = 1'b1;
               end else begin
                  result.role = ROLE_VALUE;
                  phase_in    = PH_VALUE;
               end
            end
            default: begin
               result.role = ROLE_BODY;
            end
         endcase
      end

      // Advance the capture length; saturate one past the buffer depth
      if (clear) begin
         match_len_in = '0;
      end else if (push) begin
         match_len_in = (match_len_ff < LEN_W'(MATCH_BYTES))
                        ? match_len_ff + LEN_W'(1) : LEN_W'(MATCH_BYTES + 1);
      end else begin
         match_len_in = match_len_ff;
      end
   end

   // Hold parse state; return to the start after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_METHOD;
         match_len_ff   <= '0;
         method_held_ff <= METHOD_UNKNOWN;
         skip_ff        <= 1'b0;
      end else if (step) begin
         if (last) begin
            phase_ff       <= PH_METHOD;
            match_len_ff   <= '0;
            method_held_ff <= METHOD_UNKNOWN;
            skip_ff        <= 1'b0;
         end else begin
            phase_ff       <= phase_in;
            match_len_ff   <= match_len_in;
            method_held_ff <= method_held_in;
            skip_ff        <= skip_in;
         end
      end
   end

   // Capture field bytes; entries past the length are never compared
   always_ff @(posedge clock) begin
      if (step && push && (match_len_ff < LEN_W'(MATCH_BYTES))) begin
         match_buf_ff[match_len_ff[IDX_W-1:0]] <= data_byte;
      end
   end

endmodule

[src/http_request_head_tokenizer_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata[7:0] data_byte, tlast last
// rsp_      out  rsp_tvalid/rsp_tready  tdata byte_out, method/version codes, flags;
//                                       tuser role
//
// One byte in and one result out per cycle when the output side keeps taking.
// The path runs through an input register, then the parse logic and the result
// register. Capture and code matching finish in the same cycle as the byte.
// Reset (synchronous) empties both registers and puts the parser at the method.
// A stalled output holds its result; the input register still takes one byte.

module http_request_head_tokenizer_top
   import hrht_pkg::*;
#(
   parameter int MATCH_BYTES = MATCH_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [7:0] byte_out, [11:8] method_code,
                                   // [14:12] version_code, [15] codes_valid,
                                   // [16] header_end, [17] headers_done, rest zero
   output logic [2:0]  rsp_tuser   // [2:0] role
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type parse_result;
   logic       advance;

   // Move the held item into the result register when there is room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   hrht_parse #(
      .MATCH_BYTES (MATCH_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .result    (parse_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= parse_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.role;
   assign rsp_tdata  = {6'b0,
                        out_result_ff.headers_done,
                        out_result_ff.header_end,
                        out_result_ff.codes_valid,
                        out_result_ff.version_code,
                        out_result_ff.method_code,
                        out_result_ff.byte_out};

`ifndef SYNTHESIS
   // Codes appear only on request-line bytes
   a_codes_role: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_result_ff.codes_valid) |->
         (out_result_ff.role == ROLE_METHOD || out_result_ff.role == ROLE_URI ||
          out_result_ff.role == ROLE_VER || out_result_ff.role == ROLE_SEP))
      else $error("codes reported outside the request line");

   // Codes read zero when not reported
   a_codes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_result_ff.codes_valid) |->
         (out_result_ff.method_code == METHOD_UNKNOWN &&
          out_result_ff.version_code == VERSION_UNKNOWN))
      else $error("stray method or version code");

   // End of headers is a CR tagged as end mark
   a_done_cr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_result_ff.headers_done) |->
         (out_result_ff.role == ROLE_END && out_result_ff.byte_out == CHAR_CR))
      else $error("headers_done on a byte other than an end-mark CR");

   // Header line end is a CR tagged as separator
   a_hend_cr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_result_ff.header_end) |->
         (out_result_ff.role == ROLE_SEP && out_result_ff.byte_out == CHAR_CR &&
          !out_result_ff.headers_done))
      else $error("header_end on a byte other than a separator CR");
`endif

endmodule
